// ===== rtl/heightmap_normal_generator_core_assert.svh =====
// Assertion macros shared by the heightmap normal generator RTL.
`ifndef HEIGHTMAP_NORMAL_GENERATOR_CORE_ASSERT_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_CORE_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define HNG_ASSERT_NOW(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define HNG_ASSERT_NEXT(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/hng_pkg.sv =====
// Package with the constants, types and helpers of the heightmap normal generator.
package hng_pkg;

   localparam int MaxWidth     = 1024;
   localparam int MaxRows      = 4096;
   localparam int StoreDepth   = 3 * MaxWidth;
   localparam int AddrW        = $clog2(StoreDepth);
   localparam int ColW         = $clog2(MaxWidth);
   localparam int RowW         = $clog2(MaxRows);
   localparam int OutFracBits  = 14;
   localparam int DivSteps     = 2 * OutFracBits + 3;
   localparam int SqrtSteps    = OutFracBits + 2;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HEIGHT_GAIN  = 2'd2;

   localparam logic [10:0] WIDTH_RESET  = 11'd1000;
   localparam logic [12:0] HEIGHT_RESET = 13'd1000;
   localparam logic [15:0] GAIN_RESET   = 16'd1606;

   localparam logic [47:0] SQ_Y = 48'd67108864;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_SQRT,
      ST_NEXT,
      ST_EMIT
   } state_type;

   function automatic logic [1:0] mod3_sub(input logic [1:0] rm, input logic [1:0] k);
      logic [2:0] t;
      t = {1'b0, rm} + 3'd3 - {1'b0, k};
      if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

endpackage

// ===== rtl/hng_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module hng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/heightmap_normal_generator_core.sv =====
// Top level of the heightmap normal generator: line store, sequencer and shared arithmetic unit.
// Each normal takes the line store reads, 5 multiply and sum steps, then per component a load,
// 31 division steps, 16 square root steps and a rounding step on one shared subtractor, and a
// hand-over state that waits while rsp_stall holds the output. A request causing normals keeps
// req_stall high until the last of them is handed over; one causing none leaves it low.
// Reset restores the register defaults and clears counters, pending flags, sequencer and output valid only.
`include "heightmap_normal_generator_core_assert.svh"
module heightmap_normal_generator_core import hng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_height_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normal_x,
   output logic [14:0]        rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic [9:0]         rsp_pixel_col,
   output logic [11:0]        rsp_pixel_row,
   output logic               rsp_last_of_run,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   state_type state_ff, state_in;

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [15:0] gain_ff;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [1:0]  rm_ff, rm_in;
   logic [ColW-1:0] c_lat_ff, c_lat_in;
   logic [RowW-1:0] r_lat_ff, r_lat_in;
   logic [1:0]  rm_lat_ff, rm_lat_in;
   logic [2:0]  pend_ff, pend_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  comp_ff, comp_in;
   logic [7:0]  px_ff [4];
   logic [23:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [47:0] sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [49:0] s_ff, s_in;
   logic [50:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [15:0] root_ff, root_in;
   logic [14:0] q_ff [3];
   logic        rsp_valid_ff;

   logic        accept, out_free, load_out, div_last, sqrt_last;
   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [ColW-1:0] w_last;
   logic [RowW-1:0] h_last;
   logic [2:0]  flags, kind;
   logic [ColW-1:0] ec, col_l, col_r;
   logic [RowW-1:0] er;
   logic [1:0]  m_ctr, m_prev, m_next, rd_mod;
   logic [ColW-1:0] rd_col;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [7:0]  rd_data;
   logic [23:0] mul_a, mul_b;
   logic [47:0] product, msq;
   logic [50:0] sub_a, sub_b;
   logic [51:0] diff;
   logic        ge;
   logic [16:0] root_inc;
   logic        neg_x, neg_z;

   hng_ram #(.WIDTH(8), .DEPTH(StoreDepth)) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_height_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign w_eff    = (width_ff < 11'd2) ? 11'd2 :
                     (width_ff > 11'(MaxWidth)) ? 11'(MaxWidth) : width_ff;
   assign h_eff    = (height_ff < 13'd2) ? 13'd2 :
                     (height_ff > 13'(MaxRows)) ? 13'(MaxRows) : height_ff;
   assign w_last   = ColW'(w_eff - 11'd1);
   assign h_last   = RowW'(h_eff - 13'd1);

   assign flags[0] = (row_ff != '0);
   assign flags[1] = (row_ff == h_last) && (col_ff != '0);
   assign flags[2] = (row_ff == h_last) && (col_ff == w_last);

   assign kind   = pend_ff & ~(pend_ff - 3'd1);
   assign er     = kind[0] ? RowW'(r_lat_ff - 1'b1) : r_lat_ff;
   assign ec     = kind[1] ? ColW'(c_lat_ff - 1'b1) : c_lat_ff;
   assign col_l  = (ec == '0) ? ec : ColW'(ec - 1'b1);
   assign col_r  = (ec == w_last) ? ec : ColW'(ec + 1'b1);
   assign m_ctr  = kind[0] ? mod3_sub(rm_lat_ff, 2'd1) : rm_lat_ff;
   assign m_prev = (kind[0] && r_lat_ff >= RowW'(2)) ? mod3_sub(rm_lat_ff, 2'd2)
                                                     : mod3_sub(rm_lat_ff, 2'd1);
   assign m_next = rm_lat_ff;

   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin rd_mod = m_ctr;  rd_col = col_l; end
         2'd1:    begin rd_mod = m_ctr;  rd_col = col_r; end
         2'd2:    begin rd_mod = m_prev; rd_col = ec;    end
         default: begin rd_mod = m_next; rd_col = ec;    end
      endcase
   end

   assign rd_addr = AddrW'(rd_mod * MaxWidth) + AddrW'(rd_col);
   assign wr_addr = AddrW'(rm_ff * MaxWidth) + AddrW'(col_ff);

   assign neg_x = px_ff[0] < px_ff[1];
   assign neg_z = px_ff[2] < px_ff[3];

   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin
            mul_a = {8'd0, gain_ff};
            mul_b = {16'd0, neg_x ? px_ff[1] - px_ff[0] : px_ff[0] - px_ff[1]};
         end
         2'd1:    begin
            mul_a = {8'd0, gain_ff};
            mul_b = {16'd0, neg_z ? px_ff[3] - px_ff[2] : px_ff[2] - px_ff[3]};
         end
         2'd2:    begin mul_a = ma_ff; mul_b = ma_ff; end
         default: begin mul_a = mb_ff; mul_b = mb_ff; end
      endcase
   end
   assign product = mul_a * mul_b;

   always_comb begin
      case (comp_ff)
         2'd0:    msq = sqa_ff;
         2'd1:    msq = SQ_Y;
         default: msq = sqb_ff;
      endcase
   end

   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = {rem_ff[49:0], (step_ff == '0) ? msq[0] : 1'b0};
         sub_b = {1'b0, s_ff};
      end else begin
         sub_a = {31'd0, rem_ff[17:0], quot_ff[31:30]};
         sub_b = {33'd0, root_ff, 2'b01};
      end
   end
   assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge       = !diff[51];
   assign root_inc = {1'b0, root_ff} + 17'd1;

   assign div_last  = (step_ff == 5'(DivSteps - 1));
   assign sqrt_last = (step_ff == 5'(SqrtSteps - 1));
   assign load_out  = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && flags != '0) state_in = ST_READ;
         ST_READ: if (step_ff == 5'd4) state_in = ST_MUL;
         ST_MUL:  if (step_ff == 5'd4) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  if (div_last) state_in = ST_SQRT;
         ST_SQRT: if (sqrt_last) state_in = ST_NEXT;
         ST_NEXT: state_in = (comp_ff == 2'd2) ? ST_EMIT : ST_LOAD;
         ST_EMIT: if (out_free) state_in = (pend_ff == kind) ? ST_IDLE : ST_READ;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      rm_in     = rm_ff;
      c_lat_in  = c_lat_ff;
      r_lat_in  = r_lat_ff;
      rm_lat_in = rm_lat_ff;
      pend_in   = pend_ff;
      step_in   = step_ff + 5'd1;
      comp_in   = comp_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      sqa_in    = sqa_ff;
      sqb_in    = sqb_ff;
      s_in      = s_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      root_in   = root_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            comp_in = '0;
            if (accept) begin
               c_lat_in  = col_ff;
               r_lat_in  = row_ff;
               rm_lat_in = rm_ff;
               pend_in   = flags;
               if (col_ff == w_last) begin
                  col_in = '0;
                  if (row_ff == h_last) begin
                     row_in = '0;
                     rm_in  = '0;
                  end else begin
                     row_in = row_ff + 1'b1;
                     rm_in  = mod3_sub(rm_ff, 2'd2);
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_READ: if (step_ff == 5'd4) step_in = '0;
         ST_MUL: begin
            unique case (step_ff[2:0])
               3'd0:    ma_in  = product[23:0];
               3'd1:    mb_in  = product[23:0];
               3'd2:    sqa_in = product;
               3'd3:    sqb_in = product;
               default: s_in   = {2'd0, sqa_ff} + {2'd0, sqb_ff} + {2'd0, SQ_Y};
            endcase
            if (step_ff == 5'd4) step_in = '0;
         end
         ST_LOAD: begin
            rem_in  = {4'd0, msq[47:1]};
            quot_in = '0;
            step_in = '0;
         end
         ST_DIV: begin
            rem_in  = ge ? diff[50:0] : sub_a;
            quot_in = {quot_ff[30:0], ge};
            if (div_last) begin
               rem_in  = '0;
               root_in = '0;
               step_in = '0;
            end
         end
         ST_SQRT: begin
            rem_in  = ge ? diff[50:0] : sub_a;
            root_in = {root_ff[14:0], ge};
            quot_in = {quot_ff[29:0], 2'b00};
         end
         ST_NEXT: comp_in = (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
         ST_EMIT: begin
            step_in = '0;
            comp_in = '0;
            if (out_free) pend_in = pend_ff & ~kind;
         end
         default: ;
      endcase
      if (csr_write_enable &&
          (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
         rm_in  = '0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         gain_ff      <= GAIN_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rm_ff        <= '0;
         pend_ff      <= '0;
         step_ff      <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         rm_ff    <= rm_in;
         pend_ff  <= pend_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[10:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_write_data[12:0];
               CSR_HEIGHT_GAIN:  gain_ff   <= csr_write_data;
               default: ;
            endcase
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      c_lat_ff  <= c_lat_in;
      r_lat_ff  <= r_lat_in;
      rm_lat_ff <= rm_lat_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      sqa_ff    <= sqa_in;
      sqb_ff    <= sqb_in;
      s_ff      <= s_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      root_ff   <= root_in;
      if (state_ff == ST_READ && step_ff != '0) begin
         px_ff[step_ff[1:0] - 2'd1] <= rd_data;
      end
      if (state_ff == ST_NEXT) begin
         q_ff[comp_ff] <= root_inc[15:1];
      end
      if (load_out) begin
         rsp_normal_x    <= neg_x ? -$signed({1'b0, q_ff[0]}) : $signed({1'b0, q_ff[0]});
         rsp_normal_y    <= q_ff[1];
         rsp_normal_z    <= neg_z ? -$signed({1'b0, q_ff[2]}) : $signed({1'b0, q_ff[2]});
         rsp_pixel_col   <= ec;
         rsp_pixel_row   <= er;
         rsp_last_of_run <= (pend_ff == kind);
      end
   end

   `HNG_ASSERT_NEXT(a_emit_waits, state_ff == ST_EMIT && rsp_valid_ff && rsp_stall, state_ff == ST_EMIT, "emit lost")
   `HNG_ASSERT_NOW(a_comp_range, state_ff != ST_IDLE, comp_ff != 2'd3, "component index out of range")
   `HNG_ASSERT_NOW(a_div_steps, state_ff == ST_DIV, step_ff <= 5'(DivSteps - 1), "division overrun")
   `HNG_ASSERT_NOW(a_root_cap, state_ff == ST_NEXT, root_ff <= 16'h8000, "root above unit range")

endmodule
